/* sv/key_credential_tlv_parser_defines.svh */
// ----------------------------------------------------------------------------
// Key credential TLV parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_CREDENTIAL_TLV_PARSER_DEFINES_SVH
`define KEY_CREDENTIAL_TLV_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KCTP_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("kctp assertion failed");
// Next-cycle implication
`define KCTP_ASSERT_NXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("kctp assertion failed");
`else
`define KCTP_ASSERT_IMP(name, cond, prop)
`define KCTP_ASSERT_NXT(name, cond, prop)
`endif

`endif

/* sv/kctp_pkg.sv */
// ----------------------------------------------------------------------------
// Key credential TLV parser package
// Phase codes, entry ids, timing constants and the result record.
// ----------------------------------------------------------------------------
package kctp_pkg;

	// parse phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN_LO = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_ID     = 3'd3;
	localparam logic [2:0] PH_VALUE  = 3'd4;

	// entry ids
	localparam logic [7:0] ID_USAGE = 8'h04;
	localparam logic [7:0] ID_TIME  = 8'h09;
	localparam logic [7:0] NO_USAGE = 8'hFF;

	// one day in 100 ns ticks = 52734375 << 14
	localparam logic [25:0] TICKS_DAY_ODD   = 26'd52734375;
	localparam int          TICKS_DAY_SHIFT = 14;
	localparam int          LIMIT_W         = 16 + 26 + TICKS_DAY_SHIFT;
	localparam logic [15:0] DAYS_RESET      = 16'd90;

	// APB register select (paddr bit 3)
	localparam logic REG_CURRENT_TIME = 1'b0;
	localparam logic REG_RECENT_DAYS  = 1'b1;

	typedef struct packed {
		logic        header_ok;
		logic [7:0]  key_usage;
		logic        time_found;
		logic [63:0] created_time;
	} kctp_result_t;

endpackage

/* sv/kctp_parse.sv */
// ----------------------------------------------------------------------------
// Key credential TLV parser: byte parser
// Holds the parse state; one byte per accepted beat, a final byte resets it.
// ----------------------------------------------------------------------------
module kctp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            blob_byte,
	input  logic                  final_byte,
	output kctp_pkg::kctp_result_t res
);
	import kctp_pkg::*;

	logic [2:0]  phase_q, phase_n;
	logic [1:0]  hcnt_q, hcnt_n;
	logic [15:0] len_q, len_n;
	logic [15:0] left_q, left_n;
	logic [7:0]  id_q, id_n;
	logic [63:0] shift_q, shift_n;
	logic [3:0]  idx_q, idx_n;
	logic [7:0]  usage_q, usage_n;
	logic [63:0] time_q, time_n;
	logic        seen_q, seen_n;

	always_comb begin
		phase_n = phase_q;
		hcnt_n  = hcnt_q;
		len_n   = len_q;
		left_n  = left_q;
		id_n    = id_q;
		shift_n = shift_q;
		idx_n   = idx_q;
		usage_n = usage_q;
		time_n  = time_q;
		seen_n  = seen_q;
		case (phase_q)
			PH_LEN_LO: begin
				len_n   = {8'd0, blob_byte};
				phase_n = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_n   = {blob_byte, len_q[7:0]};
				phase_n = PH_ID;
			end
			PH_ID: begin
				id_n    = blob_byte;
				left_n  = len_q;
				shift_n = '0;
				idx_n   = '0;
				phase_n = (len_q == 16'd0) ? PH_LEN_LO : PH_VALUE;
			end
			PH_VALUE: begin
				// capture only the first eight value bytes
				if (!idx_q[3]) begin
					for (int i = 0; i < 8; i++) begin
						if (idx_q[2:0] == 3'(i))
							shift_n[8*i +: 8] = blob_byte;
					end
					idx_n = idx_q + 4'd1;
				end
				left_n = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_n = PH_LEN_LO;
					if (id_q == ID_USAGE && len_q >= 16'd1) begin
						usage_n = shift_n[7:0];
					end else if (id_q == ID_TIME && len_q >= 16'd8) begin
						time_n = shift_n;
						seen_n = 1'b1;
					end
				end
			end
			default: begin
				// header phase; unused codes behave the same
				if (hcnt_q == 2'd3) begin
					hcnt_n  = 2'd0;
					phase_n = PH_LEN_LO;
				end else begin
					hcnt_n  = hcnt_q + 2'd1;
					phase_n = PH_HEADER;
				end
			end
		endcase
	end

	assign res.header_ok    = (phase_n != PH_HEADER);
	assign res.key_usage    = usage_n;
	assign res.time_found   = seen_n;
	assign res.created_time = time_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcnt_q  <= '0;
			len_q   <= '0;
			left_q  <= '0;
			id_q    <= '0;
			shift_q <= '0;
			idx_q   <= '0;
			usage_q <= NO_USAGE;
			time_q  <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (final_byte) begin
				// blob done: back to the reset parse state
				phase_q <= PH_HEADER;
				hcnt_q  <= '0;
				len_q   <= '0;
				left_q  <= '0;
				id_q    <= '0;
				shift_q <= '0;
				idx_q   <= '0;
				usage_q <= NO_USAGE;
				time_q  <= '0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				hcnt_q  <= hcnt_n;
				len_q   <= len_n;
				left_q  <= left_n;
				id_q    <= id_n;
				shift_q <= shift_n;
				idx_q   <= idx_n;
				usage_q <= usage_n;
				time_q  <= time_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule

/* sv/key_credential_tlv_parser.sv */
// ----------------------------------------------------------------------------
// Key credential TLV parser
// Walks a credential blob byte by byte and reports usage, creation time
// and recency once per blob.
// ----------------------------------------------------------------------------
// Usage:
// - Feed the blob on the s_ channel, one byte per beat in s_tdata, with
//   s_tlast high on the final byte. Bytes are taken one per cycle while s_tready is high.
// - Each blob yields one result beat on the m_ channel when its final byte
//   is taken; no result comes out for other bytes.
// - The parse itself finishes in the cycle the byte is taken. A final beat
//   taken loads the result stage, and the recency compare (64-bit subtract
//   and compare) is registered with the result in the output register,
//   which drives m_tvalid.
// - Throughput: one byte per cycle while s_tready is high.
// - When the receiver stalls, the result waits in the output register and
//   the result stage behind it; bytes keep flowing until both hold results
//   and then s_tready drops.
// - Reset clears the parse state (kept usage 255, no time), the pipeline,
//   current_time to 0 and recent_days to 90.
// - APB: current_time at 0x0, recent_days at 0x8. Write only while idle.
// ----------------------------------------------------------------------------
`include "key_credential_tlv_parser_defines.svh"

module key_credential_tlv_parser (
	input  logic        clk,
	input  logic        arst_n,
	// blob byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] blob_byte
	input  logic        s_tlast,   // final_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [0] header_ok, [8:1] key_usage, [9] time_found,
	                               // [73:10] created_time, [74] is_recent, [79:75] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import kctp_pkg::*;

	logic [63:0]        cur_time_q;
	logic [15:0]        days_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [41:0]        limit_odd;
	logic               cfg_wr;

	logic               take;
	logic               move;
	kctp_result_t       res;
	kctp_result_t       res_s1;
	logic               vld_s1;
	kctp_result_t       res_s2;
	logic               recent_s2;
	logic               vld_s2;
	logic [63:0]        age;
	logic               recent;

	// configuration registers; keep the day limit in ticks precomputed
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign limit_odd = 42'(pwdata[15:0]) * 42'(TICKS_DAY_ODD);
	assign prdata    = (paddr[3] == REG_RECENT_DAYS) ? {48'd0, days_q} : cur_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_time_q <= '0;
			days_q     <= DAYS_RESET;
			limit_q    <= LIMIT_W'(DAYS_RESET) * LIMIT_W'(TICKS_DAY_ODD) << TICKS_DAY_SHIFT;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_RECENT_DAYS) begin
				days_q  <= pwdata[15:0];
				limit_q <= {limit_odd, {TICKS_DAY_SHIFT{1'b0}}};
			end else begin
				cur_time_q <= pwdata;
			end
		end
	end

	// byte parser; advance on every accepted beat
	assign take = s_tvalid && s_tready;

	kctp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.blob_byte  (s_tdata),
		.final_byte (s_tlast),
		.res        (res)
	);

	// result stage moves to output when output is empty or being taken
	assign move     = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || move;

	// recency: nonzero time and wrapped age below the limit
	assign age    = cur_time_q - res_s1.created_time;
	assign recent = res_s1.time_found && (res_s1.created_time != 64'd0) &&
	                (age < 64'(limit_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take && s_tlast)
				vld_s1 <= 1'b1;
			else if (move)
				vld_s1 <= 1'b0;
			if (move)
				vld_s2 <= 1'b1;
			else if (m_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s_tlast)
			res_s1 <= res;
		if (move) begin
			res_s2    <= res_s1;
			recent_s2 <= recent;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {5'd0, recent_s2, res_s2.created_time, res_s2.time_found,
	                   res_s2.key_usage, res_s2.header_ok};

	`KCTP_ASSERT_NXT(a_final_loads_s1, take && s_tlast, vld_s1)
	`KCTP_ASSERT_IMP(a_recent_needs_time, vld_s2 && recent_s2, res_s2.time_found)
	`KCTP_ASSERT_IMP(a_no_time_zero, vld_s2 && !res_s2.time_found, res_s2.created_time == 64'd0)
	`KCTP_ASSERT_IMP(a_short_blob_empty, vld_s2 && !res_s2.header_ok,
		res_s2.key_usage == NO_USAGE && !res_s2.time_found)

endmodule
